@@ sv/histogram_equalizer_macros.svh @@
// Assertion macros for the histogram equalizer
`ifndef HISTOGRAM_EQUALIZER_MACROS_SVH
`define HISTOGRAM_EQUALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define HEQ_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HEQ_ASSERT_NOW(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define HEQ_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define HEQ_ASSERT_NOW(label, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/heq_pkg.sv @@
// Shared types and constants for the histogram equalizer
`default_nettype none
package heq_pkg;
  localparam int unsigned Bins = 256;
  localparam int unsigned BinW = 8;
  localparam int unsigned CntW = 23;
  localparam logic [CntW-1:0] MaxPixels = 23'd4194304;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;

  typedef enum logic {
    CMD_COUNT = 1'b0,
    CMD_MAP   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [BinW-1:0] pixel;
    logic            last;
  } item_t;
endpackage
`default_nettype wire

@@ sv/heq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module heq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ sv/heq_front.sv @@
// Input side: accepts beats into a short item queue
`default_nettype none
module heq_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire heq_pkg::item_t item_i,
  output logic                q_valid_o,
  output heq_pkg::item_t      q_item_o,
  input  wire logic           q_take_i
);
  import heq_pkg::*;
  item_t            buf_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;
  logic             wr, rd;

  assign full_o    = (cnt_q == (QPtrW+1)'(QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = buf_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = q_take_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ sv/heq_div.sv @@
// Restoring divider: quotient of num by den, one bit per cycle
`default_nettype none
module heq_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] num_i,
  input  wire logic [23:0] den_i,
  output logic             done_o,
  output logic [32:0]      quo_o
);
  logic [32:0] quo_q;
  logic [23:0] rem_q;
  logic [23:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [25:0] trial;
  logic [24:0] shifted;

  assign shifted = {rem_q, quo_q[32]};
  assign trial   = {1'b0, shifted} - {2'b0, den_q};
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd33;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // remainder stays below den, so 24 bits hold it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[25]) begin
        rem_q <= trial[23:0];
        quo_q <= {quo_q[31:0], 1'b1};
      end else begin
        rem_q <= shifted[23:0];
        quo_q <= {quo_q[31:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/heq_back.sv @@
// Execution side: histogram counting, table build and table lookup
`default_nettype none
module heq_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire heq_pkg::item_t q_item_i,
  output logic                q_take_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output logic [7:0]          pixel_out_o
);
  import heq_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN, ST_COUNT, ST_MAP, ST_OUT, ST_SCAN_RD, ST_SCAN, ST_B_RD, ST_B_WAIT,
    ST_B_START, ST_B_DIV, ST_CLEAR
  } state_e;

  state_e          state_q;
  item_t           cur_q;
  logic [CntW-1:0] total_q, run_q, cmin_q, cdf_q;
  logic            found_q, maptab_valid_q;
  logic [BinW:0]   idx_q;

  // histogram ram
  logic            h_we;
  logic [BinW-1:0] h_waddr, h_raddr;
  logic [CntW-1:0] h_wdata, h_rdata;
  // table ram
  logic            t_we;
  logic [BinW-1:0] t_waddr, t_raddr;
  logic [7:0]      t_wdata, t_rdata;
  // validity: histogram bins since last clear, table after first build
  logic [Bins-1:0] hval_q;

  logic            div_start, div_done;
  logic [32:0]     div_num, div_quo;
  logic [23:0]     div_den;
  logic [CntW-1:0] hist_val, den;
  logic [CntW-1:0] run_next;
  logic            zero_entry;

  heq_ram #(.Width(CntW), .Depth(Bins)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );
  heq_ram #(.Width(8), .Depth(Bins)) u_tab (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );
  heq_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [BinW-1:0] rd_bin_q;
  assign hist_val   = hval_q[rd_bin_q] ? h_rdata : '0;
  assign run_next   = run_q + hist_val;
  assign den        = total_q - cmin_q;
  assign zero_entry = (den == '0) || (cdf_q <= cmin_q);

  always_comb begin
    h_raddr = (state_q == ST_RUN) ? q_item_i.pixel : idx_q[BinW-1:0];
    t_raddr = q_item_i.pixel;
    h_we    = (state_q == ST_COUNT) && (total_q < MaxPixels);
    h_waddr = cur_q.pixel;
    h_wdata = hist_val + 1'b1;
    div_start = (state_q == ST_B_START) && !zero_entry;
    // 2*255*num + den over 2*den
    div_num = 33'(({10'd0, cdf_q - cmin_q}) * 33'd510) + {10'd0, den};
    div_den = {den, 1'b0};
    t_we    = 1'b0;
    t_waddr = idx_q[BinW-1:0];
    t_wdata = '0;
    if (state_q == ST_B_DIV && div_done) begin
      t_we = 1'b1;
      t_wdata = (div_quo > 33'd255) ? 8'd255 : div_quo[7:0];
    end else if (state_q == ST_B_START && zero_entry) begin
      t_we = 1'b1;
    end
  end

  assign q_take_o = (state_q == ST_RUN) && q_valid_i;
  assign empty_o  = (state_q != ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      total_q <= '0;
      run_q <= '0;
      cmin_q <= '0;
      cdf_q <= '0;
      found_q <= 1'b0;
      idx_q <= '0;
      hval_q <= '0;
      maptab_valid_q <= 1'b0;
      rd_bin_q <= '0;
      cur_q <= '0;
      pixel_out_o <= '0;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          if (q_valid_i) begin
            cur_q <= q_item_i;
            rd_bin_q <= q_item_i.pixel;
            state_q <= (q_item_i.cmd == CMD_MAP) ? ST_MAP : ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (total_q < MaxPixels) begin
            total_q <= total_q + 1'b1;
            hval_q[cur_q.pixel] <= 1'b1;
          end
          if (cur_q.last) begin
            idx_q <= '0;
            run_q <= '0;
            cmin_q <= '0;
            found_q <= 1'b0;
            state_q <= ST_SCAN_RD;
          end else begin
            state_q <= ST_RUN;
          end
        end
        ST_MAP: begin
          pixel_out_o <= maptab_valid_q ? t_rdata : 8'd0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (pop_i) state_q <= ST_RUN;
        end
        // pass 1: find cdf minimum
        ST_SCAN_RD: begin
          rd_bin_q <= idx_q[BinW-1:0];
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          run_q <= run_next;
          if (!found_q && run_next != '0) begin
            found_q <= 1'b1;
            cmin_q <= run_next;
          end
          if (idx_q == (BinW+1)'(Bins-1)) begin
            idx_q <= '0;
            run_q <= '0;
            state_q <= ST_B_RD;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= ST_SCAN_RD;
          end
        end
        // pass 2: one divide per bin, skipped for bins that map to zero
        ST_B_RD: begin
          rd_bin_q <= idx_q[BinW-1:0];
          state_q <= ST_B_WAIT;
        end
        ST_B_WAIT: begin
          run_q <= run_next;
          cdf_q <= run_next;
          state_q <= ST_B_START;
        end
        ST_B_START: begin
          state_q <= ST_B_DIV;
        end
        ST_B_DIV: begin
          if (zero_entry || div_done) begin
            if (idx_q == (BinW+1)'(Bins-1)) state_q <= ST_CLEAR;
            else begin
              idx_q <= idx_q + 1'b1;
              state_q <= ST_B_RD;
            end
          end
        end
        ST_CLEAR: begin
          hval_q <= '0;
          total_q <= '0;
          maptab_valid_q <= 1'b1;
          state_q <= ST_RUN;
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  // Entries that map to zero are written in ST_B_START without a divide;
  // ST_B_DIV then moves straight on to the next bin.
endmodule
`default_nettype wire

@@ sv/histogram_equalizer.sv @@
// Top level of the histogram equalizer. In the back end, a count beat passes
// through the run and count states; a map beat passes through the run, map and
// output states and waits in the output state until it is popped. The last
// count beat starts a table build: a scan of all 256 bins for the cdf minimum,
// then a restoring divide per bin (skipped for a bin that maps to zero), then
// a clear step; the input queue keeps accepting beats until its four entries
// are full.
`default_nettype none
`include "histogram_equalizer_macros.svh"
module histogram_equalizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       cmd_i,
  input  wire logic [7:0] pixel_i,
  input  wire logic       last_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      pixel_out_o
);
  import heq_pkg::*;
  item_t in_item, q_item;
  logic  q_valid, q_take;

  assign in_item.cmd   = cmd_e'(cmd_i);
  assign in_item.pixel = pixel_i;
  assign in_item.last  = last_i;

  heq_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_take_i(q_take)
  );
  heq_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_take_o(q_take),
    .empty_o(empty), .pop_i(pop), .pixel_out_o(pixel_out_o)
  );

  `HEQ_ASSERT_IMPL(a_take_needs_valid, clk_i, rst_ni, q_take |-> q_valid, "take on empty queue")
  `HEQ_ASSERT_IMPL(a_out_holds, clk_i, rst_ni, (!empty && !pop) |=> $stable(pixel_out_o), "held")
endmodule
`default_nettype wire
